// File: src/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types and constants of the DAC refresh sequencer.
// ----------------------------------------------------------------------------
package drs_pkg;

   // Request kinds carried on the request tuser
   localparam logic [2:0] REQ_SET    = 3'd0;
   localparam logic [2:0] REQ_GET    = 3'd1;
   localparam logic [2:0] REQ_TICK   = 3'd2;
   localparam logic [2:0] REQ_STEP   = 3'd3;
   localparam logic [2:0] REQ_RETURN = 3'd4;

   // Register indexes of the CSR map (byte address = 4 * index)
   localparam logic [2:0] CSR_UPDATE_ENABLE  = 3'd0;
   localparam logic [2:0] CSR_DENY_READ      = 3'd1;
   localparam logic [2:0] CSR_DAC_ADDRESS    = 3'd2;
   localparam logic [2:0] CSR_FB_ADDRESS     = 3'd3;
   localparam logic [2:0] CSR_STATUS_CMD     = 3'd4;
   localparam logic [2:0] CSR_CONFIG_CMD     = 3'd5;
   localparam logic [2:0] CSR_CHAN_BASE_CMD  = 3'd6;
   localparam logic [2:0] CSR_FB_BASE_CMD    = 3'd7;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Refresh requests armed by one changed channel value
   localparam logic [1:0] REFRESH_ARM_COUNT = 2'd2;

   // Load line rests high; the end-of-sequence pulse is reported per beat
   localparam logic LOAD_IDLE_LEVEL = 1'b1;

   localparam int VALUE_W = 10;
   localparam int WORD_W  = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_STATUS,
      PH_CFG_WRITE,
      PH_CFG_READ,
      PH_CH_WRITE,
      PH_CH_READ,
      PH_FINISH
   } phase_type;

   typedef struct packed {
      logic       update_enable;
      logic       deny_read;
      logic [6:0] dac_address;
      logic [6:0] fb_address;
      logic [7:0] status_cmd;
      logic [7:0] config_cmd;
      logic [7:0] chan_base_cmd;
      logic [7:0] fb_base_cmd;
   } cfg_type;

   typedef struct packed {
      phase_type phase;
      logic      txn_valid;
      logic      capture_target;
      logic      clear_target;
      logic      load_pulse;
   } ctl_cmd_type;

   typedef struct packed {
      logic updating;
      logic update_done;
   } ctl_status_type;

   typedef struct packed {
      logic        valid;
      logic        is_read;
      logic [6:0]  device;
      logic [7:0]  command;
      logic [15:0] data;
   } txn_type;

endpackage

// File: src/drs_controller.sv
// ----------------------------------------------------------------------------
// drs_controller
// Refresh request bookkeeping and the phase machine of the refresh sequence.
// ----------------------------------------------------------------------------
module drs_controller #(
   parameter int CHANNELS = 6,
   parameter int IDX_W    = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_fire,
   input  logic [2:0]               req_kind,
   input  logic                     bus_idle,
   input  logic                     set_changed,
   input  logic                     update_enable,
   input  logic                     deny_read,
   output drs_pkg::ctl_cmd_type     cmd,
   output logic [IDX_W-1:0]         seq_index,
   output drs_pkg::ctl_status_type  status
);
   import drs_pkg::*;

   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(CHANNELS - 1);

   phase_type        state_ff, state_in, eff_state;
   logic [IDX_W-1:0] seq_index_ff, seq_index_in;
   logic             request_ff, request_in;
   logic             pending_ff, pending_in;
   logic [1:0]       count_ff, count_in;
   logic             done_ff, done_in;
   logic             is_set, is_tick, is_step, start, issue;

   assign is_set  = item_fire && (req_kind == REQ_SET);
   assign is_tick = item_fire && (req_kind == REQ_TICK);
   assign is_step = item_fire && (req_kind == REQ_STEP);

   // A held request opens the sequence on the step itself
   assign start     = is_step && (state_ff == PH_IDLE) && request_ff;
   assign eff_state = start ? PH_STATUS : state_ff;
   assign issue     = is_step && bus_idle && (eff_state != PH_IDLE);

   // Next state
   always_comb begin
      state_in = eff_state;
      if (issue) begin
         case (eff_state)
            PH_STATUS:    state_in = PH_CFG_WRITE;
            PH_CFG_WRITE: state_in = PH_CFG_READ;
            PH_CFG_READ:  state_in = PH_CH_WRITE;
            PH_CH_WRITE:  state_in = PH_CH_READ;
            PH_CH_READ:   state_in = (seq_index_ff == LAST_INDEX) ? PH_FINISH : PH_CH_WRITE;
            PH_FINISH:    state_in = PH_IDLE;
            default:      state_in = PH_IDLE;
         endcase
      end
   end

   // Outputs toward the datapath
   always_comb begin
      cmd.phase          = eff_state;
      cmd.txn_valid      = issue && (eff_state != PH_FINISH);
      cmd.capture_target = issue && (eff_state == PH_CH_READ);
      cmd.clear_target   = issue && ((eff_state == PH_STATUS) || (eff_state == PH_CFG_READ));
      cmd.load_pulse     = issue && (eff_state == PH_FINISH);
   end

   // Request, pending and index bookkeeping
   always_comb begin
      seq_index_in = seq_index_ff;
      request_in   = request_ff;
      pending_in   = pending_ff;
      count_in     = count_ff;
      done_in      = done_ff;
      if (is_set && set_changed) begin
         pending_in = 1'b1;
         count_in   = REFRESH_ARM_COUNT;
      end
      if (is_tick) begin
         if (state_ff == PH_IDLE) begin
            done_in = 1'b0;
         end
         if (update_enable && !deny_read && pending_ff) begin
            if (count_ff != 2'd0) begin
               count_in   = count_ff - 2'd1;
               request_in = 1'b1;
            end
            if (count_in == 2'd0) begin
               pending_in = 1'b0;
            end
         end
      end
      if (start) begin
         request_in   = 1'b0;
         seq_index_in = '0;
      end
      if (cmd.capture_target) begin
         seq_index_in = seq_index_ff + 1'b1;
      end
      if (cmd.load_pulse) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PH_IDLE;
         seq_index_ff <= '0;
         request_ff   <= 1'b0;
         pending_ff   <= 1'b0;
         count_ff     <= 2'd0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_index_ff <= seq_index_in;
         request_ff   <= request_in;
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
      end
   end

   assign seq_index          = seq_index_ff;
   assign status.updating    = (state_in != PH_IDLE) || request_in;
   assign status.update_done = done_in;

endmodule

// File: src/drs_datapath.sv
// ----------------------------------------------------------------------------
// drs_datapath
// Channel shadow words, feedback words, read target and transaction build.
// ----------------------------------------------------------------------------
module drs_datapath #(
   parameter int CHANNELS = 6,
   parameter int IDX_W    = 3,
   parameter int ADDR_W   = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_fire,
   input  logic [2:0]            req_kind,
   input  logic [2:0]            channel,
   input  logic [15:0]           set_value,
   input  logic [15:0]           read_data,
   input  drs_pkg::cfg_type      cfg,
   input  drs_pkg::ctl_cmd_type  cmd,
   input  logic [IDX_W-1:0]      seq_index,
   output logic                  set_changed,
   output drs_pkg::txn_type      txn,
   output logic [15:0]           feedback_value
);
   import drs_pkg::*;

   localparam logic [3:0] CHAN_LIMIT = 4'(CHANNELS);

   logic [VALUE_W-1:0] chan_value_ff [CHANNELS];
   logic [WORD_W-1:0]  feedback_ff   [CHANNELS];
   logic [ADDR_W-1:0]  target_ff;
   logic               target_valid_ff;

   logic               in_range;
   logic [ADDR_W-1:0]  chan_addr, rd_addr;
   logic [VALUE_W-1:0] rd_value;
   logic [7:0]         index8;

   assign in_range  = {1'b0, channel} < CHAN_LIMIT;
   assign chan_addr = channel[ADDR_W-1:0];
   // Set compares at the request channel, a step reads at the sequence index
   assign rd_addr   = (req_kind == REQ_SET) ? chan_addr : seq_index[ADDR_W-1:0];
   assign rd_value  = chan_value_ff[rd_addr];
   assign index8    = 8'(seq_index);

   assign set_changed = in_range && (rd_value != set_value[VALUE_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            chan_value_ff[i] <= '0;
            feedback_ff[i]   <= '0;
         end
         target_ff       <= '0;
         target_valid_ff <= 1'b0;
      end else begin
         if (item_fire && (req_kind == REQ_SET) && set_changed) begin
            chan_value_ff[chan_addr] <= set_value[VALUE_W-1:0];
         end
         if (item_fire && (req_kind == REQ_RETURN) && target_valid_ff) begin
            feedback_ff[target_ff] <= read_data;
         end
         if (cmd.capture_target) begin
            target_ff       <= seq_index[ADDR_W-1:0];
            target_valid_ff <= 1'b1;
         end else if (cmd.clear_target) begin
            target_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      txn = '0;
      if (cmd.txn_valid) begin
         txn.valid = 1'b1;
         case (cmd.phase)
            PH_STATUS: begin
               txn.is_read = 1'b1;
               txn.device  = cfg.dac_address;
               txn.command = cfg.status_cmd;
            end
            PH_CFG_WRITE: begin
               txn.device  = cfg.dac_address;
               txn.command = cfg.config_cmd;
            end
            PH_CFG_READ: begin
               txn.is_read = 1'b1;
               txn.device  = cfg.dac_address;
               txn.command = cfg.config_cmd;
            end
            PH_CH_WRITE: begin
               txn.device  = cfg.dac_address;
               txn.command = cfg.chan_base_cmd + index8;
               txn.data    = {4'b0000, rd_value, 2'b00};
            end
            PH_CH_READ: begin
               txn.is_read = 1'b1;
               txn.device  = cfg.fb_address;
               txn.command = cfg.fb_base_cmd + index8;
            end
            default: txn = '0;
         endcase
      end
   end

   assign feedback_value = ((req_kind == REQ_GET) && in_range) ? feedback_ff[chan_addr] : '0;

endmodule

// File: src/dac_refresh_sequencer.sv
// ----------------------------------------------------------------------------
// dac_refresh_sequencer
// Shadow words for the DAC channels and the bus sequence that refreshes them.
// ----------------------------------------------------------------------------
// Every request beat (set, get, update tick, sequencer step, read return)
// yields exactly one response beat; a beat is accepted whenever the response
// register is empty or being drained, so the block sustains one beat per
// cycle while responses drain. The figure is set by the single response
// register: the phase machine and the channel word table are updated in the
// same cycle the beat is taken. A changed channel value arms two refresh
// requests, released one per tick while updates are enabled and feedback reads
// are allowed. In a sequence, each step with the bus idle issues one two-byte
// transaction: status read, zero configuration write, configuration read
// back, then for each channel a data write and a feedback read; a final step
// issues none, flags the load pulse and raises update_done. Read returns land
// in the channel of the last feedback read. CSRs sit at byte address 4 * index.
// ----------------------------------------------------------------------------
module dac_refresh_sequencer #(
   parameter int CHANNELS = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata, low bit first: channel[2:0], set_value[18:3], bus_idle[19],
   // read_data[35:20], zero[39:36]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [drs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: req_type[2:0]
   input  logic [2:0]                       req_tuser,
   // rsp_tdata, low bit first: txn_valid[0], txn_is_read[1], txn_device[8:2],
   // txn_command[16:9], txn_data[32:17], load_pin[33], load_pulse[34],
   // feedback_value[50:35], updating[51], update_done[52], read_denied[53],
   // zero[55:54]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [drs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [drs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [drs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [drs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import drs_pkg::*;

   localparam int IDX_W  = $clog2(CHANNELS + 1);
   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   cfg_type          cfg_ff, cfg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic             item_fire, csr_write;
   logic [2:0]       csr_index;
   logic [2:0]       req_kind, channel;
   logic [15:0]      set_value, read_data;
   logic             bus_idle;
   ctl_cmd_type      cmd;
   ctl_status_type   status;
   logic [IDX_W-1:0] seq_index;
   logic             set_changed;
   txn_type          txn;
   logic [15:0]      feedback_value;

   // Unpack the request beat
   assign req_kind  = req_tuser;
   assign channel   = req_tdata[2:0];
   assign set_value = req_tdata[18:3];
   assign bus_idle  = req_tdata[19];
   assign read_data = req_tdata[35:20];

   // Accept while the response register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign item_fire  = req_tvalid && req_tready;

   // CSR port: writes land on the access cycle, reads return the register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_UPDATE_ENABLE: cfg_in.update_enable = csr_pwdata[0];
            CSR_DENY_READ:     cfg_in.deny_read     = csr_pwdata[0];
            CSR_DAC_ADDRESS:   cfg_in.dac_address   = csr_pwdata[6:0];
            CSR_FB_ADDRESS:    cfg_in.fb_address    = csr_pwdata[6:0];
            CSR_STATUS_CMD:    cfg_in.status_cmd    = csr_pwdata[7:0];
            CSR_CONFIG_CMD:    cfg_in.config_cmd    = csr_pwdata[7:0];
            CSR_CHAN_BASE_CMD: cfg_in.chan_base_cmd = csr_pwdata[7:0];
            CSR_FB_BASE_CMD:   cfg_in.fb_base_cmd   = csr_pwdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_UPDATE_ENABLE: csr_prdata = 32'(cfg_ff.update_enable);
         CSR_DENY_READ:     csr_prdata = 32'(cfg_ff.deny_read);
         CSR_DAC_ADDRESS:   csr_prdata = 32'(cfg_ff.dac_address);
         CSR_FB_ADDRESS:    csr_prdata = 32'(cfg_ff.fb_address);
         CSR_STATUS_CMD:    csr_prdata = 32'(cfg_ff.status_cmd);
         CSR_CONFIG_CMD:    csr_prdata = 32'(cfg_ff.config_cmd);
         CSR_CHAN_BASE_CMD: csr_prdata = 32'(cfg_ff.chan_base_cmd);
         CSR_FB_BASE_CMD:   csr_prdata = 32'(cfg_ff.fb_base_cmd);
         default:           csr_prdata = '0;
      endcase
   end

   drs_controller #(
      .CHANNELS (CHANNELS),
      .IDX_W    (IDX_W)
   ) u_controller (
      .clock         (clock),
      .reset         (reset),
      .item_fire     (item_fire),
      .req_kind      (req_kind),
      .bus_idle      (bus_idle),
      .set_changed   (set_changed),
      .update_enable (cfg_ff.update_enable),
      .deny_read     (cfg_ff.deny_read),
      .cmd           (cmd),
      .seq_index     (seq_index),
      .status        (status)
   );

   drs_datapath #(
      .CHANNELS (CHANNELS),
      .IDX_W    (IDX_W),
      .ADDR_W   (ADDR_W)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .item_fire      (item_fire),
      .req_kind       (req_kind),
      .channel        (channel),
      .set_value      (set_value),
      .read_data      (read_data),
      .cfg            (cfg_ff),
      .cmd            (cmd),
      .seq_index      (seq_index),
      .set_changed    (set_changed),
      .txn            (txn),
      .feedback_value (feedback_value)
   );

   // Pack the response beat; read_denied shows the deny setting as it stands
   assign rsp_data_in = {2'b00,
                         cfg_ff.deny_read,
                         status.update_done,
                         status.updating,
                         feedback_value,
                         cmd.load_pulse,
                         LOAD_IDLE_LEVEL,
                         txn.data,
                         txn.command,
                         txn.device,
                         txn.is_read,
                         txn.valid};

   // Load a fresh beat on accept, drop the old one once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff         <= 1'b0;
         cfg_ff.update_enable <= 1'b1;
         cfg_ff.deny_read     <= 1'b0;
         cfg_ff.dac_address   <= 7'd72;
         cfg_ff.fb_address    <= 7'd73;
         cfg_ff.status_cmd    <= 8'd2;
         cfg_ff.config_cmd    <= 8'd1;
         cfg_ff.chan_base_cmd <= 8'd8;
         cfg_ff.fb_base_cmd   <= 8'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: src/drs_checker.sv
// ----------------------------------------------------------------------------
// drs_checker
// Port-level checks on the response beats of the DAC refresh sequencer.
// ----------------------------------------------------------------------------
module drs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   // Hold a stalled beat
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // No transaction means empty transaction fields
   a_idle_txn: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[32:1] == 32'd0)
      else $error("transaction fields set without txn_valid");

   // Reads carry no write word
   a_read_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] && rsp_tdata[1] |-> rsp_tdata[32:17] == 16'd0)
      else $error("read transaction with nonzero data");

   // Load pulse closes the sequence: no transaction, done raised, line high
   a_load_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34] |-> !rsp_tdata[0] && rsp_tdata[52] && rsp_tdata[33])
      else $error("load pulse outside sequence end");

endmodule

bind dac_refresh_sequencer drs_checker u_drs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
